/* hw/rtl/rbs_pkg.sv */
`default_nettype none
package rbs_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 9;
    localparam int BW_W     = 16;
    localparam int VAR_W    = 64;
    localparam int SD_W     = 32;

    localparam logic [0:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [0:0] CFG_BAND_WIDTH    = 1'd1;

    typedef struct packed {
        logic clear;
        logic rd_req;
        logic sum_acc;
        logic mean_start;
        logic sq_acc;
        logic var_start;
        logic sqrt_start;
        logic band_calc;
        logic out_load;
        logic out_zero;
    } cmd_t;

    typedef struct packed {
        logic mean_done;
        logic var_done;
        logic sqrt_done;
    } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/rbs_if.sv */
`default_nettype none
interface rbs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rbs_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] middle;
    logic [31:0] upper;
    logic [31:0] lower;
    modport source (output valid, output valid_res, output middle, output upper, output lower,
                    input ready);
    modport sink   (input valid, input valid_res, input middle, input upper, input lower,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/rbs_ram.sv */
`default_nettype none
module rbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/rbs_datapath.sv */
`default_nettype none
module rbs_datapath #(
    parameter int WINDOW_MAX = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rbs_pkg::cmd_t            cmd,
    output rbs_pkg::sts_t                 sts,
    input  wire logic [rbs_pkg::WLEN_W-1:0] wlen,
    input  wire logic [rbs_pkg::BW_W-1:0] bw,
    input  wire logic [31:0]              rd_data,
    output logic                          res_valid,
    output logic [31:0]                   res_middle,
    output logic [31:0]                   res_upper,
    output logic [31:0]                   res_lower
);
    localparam int SUM_W = 32 + $clog2(WINDOW_MAX) + 1;
    // sum of up to WINDOW_MAX squares of 33-bit deviations
    localparam int SQ_W  = 66 + $clog2(WINDOW_MAX);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [32:0]      mean_reg;       // fits 32 bits, kept signed
    logic [SQ_W-1:0]         sq_reg;
    logic [63:0]             var_reg;
    logic [31:0]             sd_reg;
    logic [47:0]             dev_reg;

    // mean divider: restoring on |sum|
    logic [SUM_W-1:0]  mq_reg, mr_reg;
    logic [6:0]        mcnt_reg;
    logic              mbusy_reg, mneg_reg;
    // variance divider on sq
    logic [SQ_W-1:0]   vq_reg;
    logic [SQ_W-1:0]   vr_reg;
    logic [6:0]        vcnt_reg;
    logic              vbusy_reg;
    // isqrt
    logic [63:0]       sv_reg, sres_reg, sbit_reg;
    logic              sbusy_reg;

    logic signed [32:0] rd_s;
    logic signed [33:0] diff;
    logic [32:0]        absd;
    logic [65:0]        sq_term;
    logic [SUM_W-1:0]   mr_sh;
    logic [SQ_W-1:0]    vr_sh;
    logic [63:0]        s_trial;
    logic signed [49:0] up_w, lo_w;

    assign rd_s    = {rd_data[31], rd_data};
    assign diff    = {rd_s[32], rd_s} - {mean_reg[32], mean_reg};
    assign absd    = diff[33] ? 33'(-diff) : diff[32:0];
    assign sq_term = 66'(absd) * 66'(absd);
    assign mr_sh   = {mr_reg[SUM_W-2:0], mq_reg[SUM_W-1]};
    assign vr_sh   = {vr_reg[SQ_W-2:0], vq_reg[SQ_W-1]};
    assign s_trial = sres_reg + sbit_reg;
    assign up_w    = 50'(mean_reg) + 50'(dev_reg);
    assign lo_w    = 50'(mean_reg) - 50'(dev_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            vbusy_reg <= 1'b0;
            sbusy_reg <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                sum_reg <= '0;
                sq_reg  <= '0;
            end
            if (cmd.sum_acc)
            begin
                sum_reg <= sum_reg + SUM_W'(rd_s);
            end
            if (cmd.sq_acc)
            begin
                sq_reg <= sq_reg + SQ_W'(sq_term);
            end
            if (cmd.mean_start)
            begin
                mneg_reg  <= sum_reg[SUM_W-1];
                mq_reg    <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                mr_reg    <= '0;
                mcnt_reg  <= 7'(SUM_W);
                mbusy_reg <= 1'b1;
            end
            else if (mbusy_reg)
            begin
                if (mcnt_reg == 7'd0)
                begin
                    mbusy_reg <= 1'b0;
                    mean_reg  <= mneg_reg ? 33'(-$signed({1'b0, mq_reg}))
                                          : 33'($signed({1'b0, mq_reg}));
                end
                else
                begin
                    mcnt_reg <= mcnt_reg - 7'd1;
                    if (mr_sh >= SUM_W'(wlen))
                    begin
                        mr_reg <= mr_sh - SUM_W'(wlen);
                        mq_reg <= {mq_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        mr_reg <= mr_sh;
                        mq_reg <= {mq_reg[SUM_W-2:0], 1'b0};
                    end
                end
            end
            if (cmd.var_start)
            begin
                vq_reg    <= sq_reg;
                vr_reg    <= '0;
                vcnt_reg  <= 7'(SQ_W);
                vbusy_reg <= 1'b1;
            end
            else if (vbusy_reg)
            begin
                if (vcnt_reg == 7'd0)
                begin
                    vbusy_reg <= 1'b0;
                    var_reg   <= vq_reg[63:0];
                end
                else
                begin
                    vcnt_reg <= vcnt_reg - 7'd1;
                    if (vr_sh >= SQ_W'(wlen))
                    begin
                        vr_reg <= vr_sh - SQ_W'(wlen);
                        vq_reg <= {vq_reg[SQ_W-2:0], 1'b1};
                    end
                    else
                    begin
                        vr_reg <= vr_sh;
                        vq_reg <= {vq_reg[SQ_W-2:0], 1'b0};
                    end
                end
            end
            if (cmd.sqrt_start)
            begin
                sv_reg    <= var_reg;
                sres_reg  <= '0;
                sbit_reg  <= 64'd1 << 62;
                sbusy_reg <= 1'b1;
            end
            else if (sbusy_reg)
            begin
                if (sbit_reg == 64'd0)
                begin
                    sbusy_reg <= 1'b0;
                    sd_reg    <= sres_reg[31:0];
                end
                else
                begin
                    // skipping the leading "bit > v" search is harmless: trial fails
                    if (sv_reg >= s_trial)
                    begin
                        sv_reg   <= sv_reg - s_trial;
                        sres_reg <= (sres_reg >> 1) + sbit_reg;
                    end
                    else
                    begin
                        sres_reg <= sres_reg >> 1;
                    end
                    sbit_reg <= sbit_reg >> 2;
                end
            end
            if (cmd.band_calc)
            begin
                dev_reg <= 48'((64'(bw) * 64'(sd_reg)) >> 12);
            end
            if (cmd.out_zero)
            begin
                res_valid  <= 1'b0;
                res_middle <= '0;
                res_upper  <= '0;
                res_lower  <= '0;
            end
            else if (cmd.out_load)
            begin
                res_valid  <= 1'b1;
                res_middle <= mean_reg[31:0];
                res_upper  <= (up_w > 50'sh7FFFFFFF) ? 32'h7FFFFFFF : up_w[31:0];
                res_lower  <= (lo_w < -50'sh80000000) ? 32'h80000000 : lo_w[31:0];
            end
        end
    end

    assign sts.mean_done = mbusy_reg && (mcnt_reg == 7'd0);
    assign sts.var_done  = vbusy_reg && (vcnt_reg == 7'd0);
    assign sts.sqrt_done = sbusy_reg && (sbit_reg == 64'd0);

    property p_div_excl;
        @(posedge clk) disable iff (!rst_n) !(mbusy_reg && vbusy_reg);
    endproperty
    a_div_excl: assert property (p_div_excl) else $error("dividers overlap");

    property p_sqrt_excl;
        @(posedge clk) disable iff (!rst_n) !(sbusy_reg && (mbusy_reg || vbusy_reg));
    endproperty
    a_sqrt_excl: assert property (p_sqrt_excl) else $error("sqrt overlaps divider");

    property p_mean_done;
        @(posedge clk) disable iff (!rst_n) sts.mean_done |=> !mbusy_reg;
    endproperty
    a_mean_done: assert property (p_mean_done) else $error("mean divider stuck");
endmodule
`default_nettype wire

/* hw/rtl/rbs_ctrl.sv */
`default_nettype none
module rbs_ctrl #(
    parameter int WINDOW_MAX = 256
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    input  wire logic [rbs_pkg::WLEN_W-1:0]   wlen,
    input  wire logic [rbs_pkg::BW_W-1:0]     bw,
    input  wire rbs_pkg::sts_t                sts,
    output rbs_pkg::cmd_t                     cmd,
    output logic                              ram_we,
    output logic [$clog2(WINDOW_MAX)-1:0]     waddr,
    output logic [$clog2(WINDOW_MAX)-1:0]     raddr
);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SUM   = 9'b000000010,
        ST_MEAN  = 9'b000000100,
        ST_SQ    = 9'b000001000,
        ST_VAR   = 9'b000010000,
        ST_SQRT  = 9'b000100000,
        ST_BAND  = 9'b001000000,
        ST_LOAD  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   widx_reg;
    logic [CW-1:0]   cnt_reg;
    logic [AW-1:0]   rptr_reg;
    logic [8:0]      k_reg;      // reads issued
    logic            pend_reg;   // read data arrives next cycle
    logic            last_reg;
    logic            accept, ok;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign ram_we   = accept;
    assign waddr    = widx_reg;
    assign raddr    = rptr_reg;

    // count includes the item just written
    assign ok = (wlen != '0) && (bw != '0) && (CW'(wlen) <= cnt_reg)
                && (32'(wlen) <= 32'(WINDOW_MAX));

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;   // LOAD checks ok after count update
                end
            end
            ST_LOAD:
            begin
                cmd.clear = 1'b1;
                if (ok)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    cmd.out_zero = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SUM:
            begin
                cmd.sum_acc = pend_reg;
                if (pend_reg && last_reg)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                cmd.mean_start = !sts.mean_done && !pend_reg;
                if (sts.mean_done)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq_acc = pend_reg;
                if (pend_reg && last_reg)
                begin
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                cmd.var_start = !pend_reg && !sts.var_done;
                if (sts.var_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_start = !pend_reg && !sts.sqrt_done;
                if (sts.sqrt_done)
                begin
                    state_next = ST_BAND;
                end
            end
            ST_BAND:
            begin
                if (!pend_reg)
                begin
                    cmd.band_calc = 1'b1;
                end
                else
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // in the unit states pend_reg marks "start issued", held until the unit is done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            widx_reg  <= '0;
            cnt_reg   <= '0;
            rptr_reg  <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                widx_reg <= widx_reg + AW'(1);
                if (cnt_reg != CW'(WINDOW_MAX))
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            case (state_reg)
                ST_LOAD, ST_MEAN:
                begin
                    rptr_reg <= widx_reg - AW'(1);
                    k_reg    <= '0;
                    pend_reg <= (state_reg == ST_MEAN) && !sts.mean_done
                                && (pend_reg || cmd.mean_start);
                    last_reg <= 1'b0;
                end
                ST_SUM, ST_SQ:
                begin
                    if (k_reg < 9'(wlen))
                    begin
                        rptr_reg <= rptr_reg - AW'(1);
                        k_reg    <= k_reg + 9'd1;
                        pend_reg <= 1'b1;
                        last_reg <= (k_reg + 9'd1 == 9'(wlen));
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                ST_VAR:
                begin
                    pend_reg <= !sts.var_done && (pend_reg || cmd.var_start);
                end
                ST_SQRT:
                begin
                    pend_reg <= !sts.sqrt_done && (pend_reg || cmd.sqrt_start);
                end
                ST_BAND:
                begin
                    pend_reg <= cmd.band_calc;
                end
                default:
                begin
                    pend_reg <= 1'b0;
                end
            endcase
        end
    end

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("input taken during output");

    property p_cnt_sat;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(WINDOW_MAX);
    endproperty
    a_cnt_sat: assert property (p_cnt_sat) else $error("count overflow");

    property p_accept_goes;
        @(posedge clk) disable iff (!rst_n) accept |=> (state_reg == ST_LOAD);
    endproperty
    a_accept_goes: assert property (p_accept_goes) else $error("accept lost");
endmodule
`default_nettype wire

/* hw/rtl/rolling_band_statistics_top.sv */
// Result computation (WINDOW_MAX 256): two read passes over the sample ring (one read per
// cycle), a 41-step mean divider, a 74-step variance divider and a 32-step sqrt.
// Items are processed one at a time; a new sample is accepted only after the result is taken.
// Disabled or short-window items give a zero result.
// Reset (rst_n, async low): registers to 20 / 8192, ring index and count to 0.
`default_nettype none
module rolling_band_statistics_top #(
    parameter int WINDOW_MAX = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rbs_in_if.sink           in_ch,
    rbs_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = $clog2(WINDOW_MAX);

    logic [rbs_pkg::WLEN_W-1:0] wlen_reg;
    logic [rbs_pkg::BW_W-1:0]   bw_reg;
    rbs_pkg::cmd_t cmd;
    rbs_pkg::sts_t sts;
    logic          ram_we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= 9'd20;
            bw_reg   <= 16'd8192;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbs_pkg::CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[8:0];
                rbs_pkg::CFG_BAND_WIDTH:    bw_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    rbs_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (in_ch.sample),
        .raddr (raddr),
        .rdata (rd_data)
    );

    rbs_ctrl #(.WINDOW_MAX(WINDOW_MAX)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .wlen      (wlen_reg),
        .bw        (bw_reg),
        .sts       (sts),
        .cmd       (cmd),
        .ram_we    (ram_we),
        .waddr     (waddr),
        .raddr     (raddr)
    );

    rbs_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .wlen       (wlen_reg),
        .bw         (bw_reg),
        .rd_data    (rd_data),
        .res_valid  (out_ch.valid_res),
        .res_middle (out_ch.middle),
        .res_upper  (out_ch.upper),
        .res_lower  (out_ch.lower)
    );
endmodule
`default_nettype wire

/* tb/sv/tb_rolling_band_statistics_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_rolling_band_statistics_top;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] middle;
        logic [31:0] upper;
        logic [31:0] lower;
    } band_t;

    // Software copy of the band statistics, plus the queue of pending bands.
    class band_scoreboard;
        logic [31:0] ring [256];
        int unsigned wr_idx;
        int unsigned count;
        int unsigned win_len;
        int unsigned bw;
        band_t       pending [$];
        int          errors;
        int          checked;
        int          valid_seen;

        function void reset_state();
            wr_idx = 0;
            count = 0;
            win_len = 20;
            bw = 8192;
            pending.delete();
            errors = 0;
            checked = 0;
            valid_seen = 0;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void note_sample(logic [31:0] s);
            band_t       r;
            longint      total;
            longint      avg;
            longint      d;
            logic [127:0] sq;
            logic [127:0] var_q;
            logic [63:0] sd;
            logic [63:0] dev;
            int unsigned idx;
            ring[wr_idx] = s;
            wr_idx = (wr_idx + 1) % 256;
            if (count < 256)
                count++;
            r = '0;
            if (win_len != 0 && bw != 0 && win_len <= 256 && count >= win_len)
            begin
                total = 0;
                for (int k = 0; k < win_len; k++)
                begin
                    idx = (wr_idx + 255 - k) % 256;
                    total += longint'($signed(ring[idx]));
                end
                avg = total / longint'(win_len);
                sq = 0;
                for (int k = 0; k < win_len; k++)
                begin
                    idx = (wr_idx + 255 - k) % 256;
                    d = longint'($signed(ring[idx])) - avg;
                    if (d < 0)
                        d = -d;
                    sq += 128'(d) * 128'(d);
                end
                var_q = sq / 128'(win_len);
                sd = floor_sqrt(var_q[63:0]);
                dev = (64'(bw) * sd) >> 12;
                r.valid_res = 1'b1;
                r.middle = avg[31:0];
                r.upper = 32'(clamp32(avg + longint'(dev)));
                r.lower = 32'(clamp32(avg - longint'(dev)));
            end
            pending.push_back(r);
        endfunction

        function void check_band(band_t got);
            band_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result item valid_res=%0b middle=%h", got.valid_res,
                       got.middle);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.valid_res)
                valid_seen++;
            if (got.valid_res !== e.valid_res)
            begin
                $error("valid_res: expected %0b actual %0b", e.valid_res, got.valid_res);
                errors++;
            end
            if (got.middle !== e.middle)
            begin
                $error("middle: expected %h actual %h", e.middle, got.middle);
                errors++;
            end
            if (got.upper !== e.upper)
            begin
                $error("upper: expected %h actual %h", e.upper, got.upper);
                errors++;
            end
            if (got.lower !== e.lower)
            begin
                $error("lower: expected %h actual %h", e.lower, got.lower);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycles;
    int          sent;

    band_scoreboard sb;

    rbs_in_if  in_ch ();
    rbs_out_if out_ch ();

    rolling_band_statistics_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd6000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, check on handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_band({out_ch.valid_res, out_ch.middle, out_ch.upper, out_ch.lower});
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // cfg_we drops again after each write and the task idles before returning, keeping cfg_we to one update per edge
    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rbs_pkg::CFG_WINDOW_LENGTH)
            sb.win_len = val[8:0];
        else
            sb.bw = val;
        @(posedge clk);
    endtask

    // valid stays high after accept; the next call or drain() updates it
    task automatic send_sample(logic [31:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_sample(s);
        sent++;
    endtask

    // waits for all bands, then covers the latency of a full-window item
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(int'($urandom_range(2000000)) - 1000000) + 32'h00640000;
        endcase
    endfunction

    initial
    begin
        sb = new();
        sb.reset_state();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rbs_pkg::CFG_WINDOW_LENGTH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, too few samples, extremes and band overflow
        for (int i = 0; i < 21; i++)
            send_sample(i[0] ? 32'h7fffffff : 32'h80000000);
        send_sample(32'h0);
        send_sample(32'hffffffff);
        drain();
        write_reg(rbs_pkg::CFG_BAND_WIDTH, 16'hffff);
        write_reg(rbs_pkg::CFG_WINDOW_LENGTH, 16'd2);
        send_sample(32'h7fffffff);
        send_sample(32'h80000000);
        send_sample(32'h00010000);
        drain();
        write_reg(rbs_pkg::CFG_BAND_WIDTH, 16'd0);
        send_sample(32'h12345678);
        drain();
        write_reg(rbs_pkg::CFG_BAND_WIDTH, 16'd4096);
        write_reg(rbs_pkg::CFG_WINDOW_LENGTH, 16'd0);
        send_sample(32'h1);
        drain();
        write_reg(rbs_pkg::CFG_WINDOW_LENGTH, 16'd257);
        send_sample(32'h2);
        drain();

        // random phases across settings and idling mixes
        for (int ph = 0; ph < 12; ph++)
        begin
            int wl;
            int n;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            case (ph)
                3: wl = 256;
                7: wl = 1;
                10: wl = 0;
                default: wl = $urandom_range(2, 40);
            endcase
            write_reg(rbs_pkg::CFG_WINDOW_LENGTH, 16'(wl));
            write_reg(rbs_pkg::CFG_BAND_WIDTH,
                      (ph == 5) ? 16'hffff : 16'($urandom_range(1, 65535)));
            n = (wl == 256) ? 40 : 80;
            for (int i = 0; i < n; i++)
                send_sample(rand_sample());
            drain();
        end

        $display("Checked %0d band results (%0d valid) from %0d samples over 12 phases.",
                 sb.checked, sb.valid_seen, sent);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_if.sv
hw/rtl/rbs_ram.sv
hw/rtl/rbs_datapath.sv
hw/rtl/rbs_ctrl.sv
hw/rtl/rolling_band_statistics_top.sv
tb/sv/tb_rolling_band_statistics_top.sv
